// File: design/dvbapi_v3_message_parser_macros.svh
// ----------------------------------------------------------------------------
// DVB API v3 message parser assertion macros
// Assertion wrappers that compile to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef DVBAPI_V3_MESSAGE_PARSER_MACROS_SVH
`define DVBAPI_V3_MESSAGE_PARSER_MACROS_SVH

`ifndef SYNTHESIS
`define DVBAPI_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define DVBAPI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DVBAPI_ASSERT(lbl, clk, rstn, prop, msg)
`define DVBAPI_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: design/dvbapi_pkg.sv
// ----------------------------------------------------------------------------
// DVB API v3 parser package
// Shared types, opcodes and event codes of the message parser.
// ----------------------------------------------------------------------------
package dvbapi_pkg;

    localparam logic [31:0] OP_SET_DESCR      = 32'h4010_6F86;
    localparam logic [31:0] OP_SET_DESCR_MODE = 32'h400C_6F88;
    localparam logic [31:0] OP_SET_DESCR_DATA = 32'h4018_6F89;
    localparam logic [31:0] OP_DMX_SET_FILTER = 32'h403C_6F2B;
    localparam logic [31:0] OP_DMX_STOP       = 32'h0000_6F2A;
    localparam logic [31:0] OP_SERVER_INFO    = 32'hFFFF_0002;
    localparam logic [31:0] OP_ECM_INFO       = 32'hFFFF_0003;
    localparam logic [7:0]  FRAME_MARKER      = 8'hA5;

    localparam logic [1:0] KIND_CONTROL_WORD = 2'd0;
    localparam logic [1:0] KIND_DESCR_MODE   = 2'd1;
    localparam logic [1:0] KIND_SERVER_INFO  = 2'd2;
    localparam logic [1:0] KIND_ERROR        = 2'd3;

    localparam logic [1:0] ERR_BAD_MARKER = 2'd0;
    localparam logic [1:0] ERR_DEMUX      = 2'd1;
    localparam logic [1:0] ERR_UNKNOWN    = 2'd2;

    localparam int PAYLOAD_DEPTH = 16;

    typedef enum logic [11:0] {
        PH_HUNT    = 12'b0000_0000_0001,
        PH_HEADER  = 12'b0000_0000_0010,
        PH_DESCR   = 12'b0000_0000_0100,
        PH_MODE    = 12'b0000_0000_1000,
        PH_DDHDR   = 12'b0000_0001_0000,
        PH_DDSKIP  = 12'b0000_0010_0000,
        PH_SRVHDR  = 12'b0000_0100_0000,
        PH_SRVNAME = 12'b0000_1000_0000,
        PH_ECMFIX  = 12'b0001_0000_0000,
        PH_ECMLEN  = 12'b0010_0000_0000,
        PH_ECMSTR  = 12'b0100_0000_0000,
        PH_HOPS    = 12'b1000_0000_0000
    } t_phase;

    typedef struct packed {
        logic       restart;
        logic [7:0] data;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  error_code;
        logic [15:0] protocol_version;
        logic [31:0] scramble_mode;
        logic [31:0] algorithm;
        logic [63:0] control_word;
        logic [31:0] parity;
        logic [31:0] echo_id;
        logic [1:0]  event_kind;
    } t_result;

endpackage

// File: design/dvbapi_v3_message_parser.sv
// ----------------------------------------------------------------------------
// DVB API v3 message parser
// Deframes the server-to-client byte stream into control-word, descriptor-
// mode, server-info and protocol-error events.
// ----------------------------------------------------------------------------
// The slave channel carries one stream byte per transaction in s_axis_tdata;
// s_axis_tuser set drops any partial message and the byte is ignored.
// The master channel carries one event per transaction: the kind in
// m_axis_tuser and all event fields in m_axis_tdata, unused fields zero.
// A byte passes an input register and then the parser state machine, which
// writes the event into the result register, from which it is valid on the
// master channel. One byte is taken every cycle, with no gaps between
// messages, unless an event byte waits on a stalled receiver, as below.
// When the receiver stalls, bytes that complete no event keep flowing; a
// byte that would raise a second event waits in the input register and
// s_axis_tready drops until the pending event is taken.
// Reset clears both registers and puts the parser into marker hunting.
// ----------------------------------------------------------------------------
module dvbapi_v3_message_parser (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,  // stream_byte
    input  logic [0:0]   s_axis_tuser,  // link_restart
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // echo_id, parity, control_word, algorithm, scramble_mode,
    // protocol_version, error_code, zero fill
    output logic [215:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser   // event_kind
);

    dvbapi_pkg::t_in_item w_in_item;
    dvbapi_pkg::t_in_item w_core_item;
    dvbapi_pkg::t_result  w_core_result;
    dvbapi_pkg::t_result  w_out_result;
    logic                 w_core_valid;
    logic                 w_take;
    logic                 w_has_result;
    logic                 w_out_free;

    assign w_in_item.data    = s_axis_tdata;
    assign w_in_item.restart = s_axis_tuser[0];

    dvbapi_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (w_in_item),
        .i_take  (w_take),
        .o_valid (w_core_valid),
        .o_item  (w_core_item)
    );

    dvbapi_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_core_valid),
        .i_item       (w_core_item),
        .i_out_free   (w_out_free),
        .o_take       (w_take),
        .o_has_result (w_has_result),
        .o_result     (w_core_result)
    );

    dvbapi_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_take && w_has_result),
        .i_result (w_core_result),
        .i_ready  (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_free   (w_out_free),
        .o_result (w_out_result)
    );

    assign m_axis_tdata = {6'd0, w_out_result.error_code, w_out_result.protocol_version,
                           w_out_result.scramble_mode, w_out_result.algorithm,
                           w_out_result.control_word, w_out_result.parity,
                           w_out_result.echo_id};
    assign m_axis_tuser = w_out_result.event_kind;

endmodule

// File: design/dvbapi_in_stage.sv
// ----------------------------------------------------------------------------
// DVB API parser input stage
// Holds one received byte until the parser core consumes it.
// ----------------------------------------------------------------------------
module dvbapi_in_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  dvbapi_pkg::t_in_item i_item,
    input  logic                 i_take,
    output logic                 o_valid,
    output dvbapi_pkg::t_in_item o_item
);

    logic                 r_valid;
    logic                 n_valid;
    dvbapi_pkg::t_in_item r_item;
    logic                 w_accept;

    assign o_ready  = !r_valid || i_take;
    assign w_accept = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: design/dvbapi_core.sv
// ----------------------------------------------------------------------------
// DVB API parser core
// Message state machine; consumes one byte per step and forms the event.
// ----------------------------------------------------------------------------
`include "dvbapi_v3_message_parser_macros.svh"

module dvbapi_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  dvbapi_pkg::t_in_item i_item,
    input  logic                 i_out_free,
    output logic                 o_take,
    output logic                 o_has_result,
    output dvbapi_pkg::t_result  o_result
);

    dvbapi_pkg::t_phase r_phase;
    dvbapi_pkg::t_phase n_phase;
    logic [4:0]         r_bc;
    logic [4:0]         n_bc;
    logic [31:0]        r_mid;
    logic [31:0]        n_mid;
    logic [31:0]        r_opc;
    logic [31:0]        n_opc;
    logic [31:0]        r_skip;
    logic [31:0]        n_skip;
    logic [2:0]         r_si;
    logic [2:0]         n_si;
    logic [7:0]         r_payload [dvbapi_pkg::PAYLOAD_DEPTH];

    logic [7:0]          w_byte;
    logic [4:0]          w_bc_inc;
    logic [31:0]         w_skip_dec;
    logic [2:0]          w_si_inc;
    logic [31:0]         w_opc_shift;
    logic                w_store;
    logic                w_has;
    dvbapi_pkg::t_result w_res;

    assign w_byte      = i_item.data;
    assign w_bc_inc    = r_bc + 5'd1;
    assign w_skip_dec  = r_skip - 32'd1;
    assign w_si_inc    = r_si + 3'd1;
    assign w_opc_shift = {r_opc[23:0], w_byte};
    assign w_store     = r_phase inside {dvbapi_pkg::PH_DESCR, dvbapi_pkg::PH_MODE,
                                         dvbapi_pkg::PH_DDHDR, dvbapi_pkg::PH_SRVHDR,
                                         dvbapi_pkg::PH_ECMFIX};

    always_comb begin
        n_phase = r_phase;
        n_bc    = r_bc;
        n_mid   = r_mid;
        n_opc   = r_opc;
        n_skip  = r_skip;
        n_si    = r_si;
        w_has   = 1'b0;
        w_res   = '0;
        if (i_item.restart) begin
            n_phase = dvbapi_pkg::PH_HUNT;
            n_bc    = 5'd0;
            n_skip  = 32'd0;
            n_si    = 3'd0;
        end else begin
            case (r_phase)
                dvbapi_pkg::PH_HUNT: begin
                    if (w_byte == dvbapi_pkg::FRAME_MARKER) begin
                        n_phase = dvbapi_pkg::PH_HEADER;
                        n_bc    = 5'd0;
                    end else begin
                        w_has            = 1'b1;
                        w_res.event_kind = dvbapi_pkg::KIND_ERROR;
                        w_res.error_code = dvbapi_pkg::ERR_BAD_MARKER;
                    end
                end
                dvbapi_pkg::PH_HEADER: begin
                    if (r_bc < 5'd4) begin
                        n_mid = {r_mid[23:0], w_byte};
                    end else begin
                        n_opc = w_opc_shift;
                    end
                    n_bc = w_bc_inc;
                    if (w_bc_inc == 5'd8) begin
                        n_bc = 5'd0;
                        case (w_opc_shift)
                            dvbapi_pkg::OP_SET_DESCR: begin
                                n_phase = dvbapi_pkg::PH_DESCR;
                            end
                            dvbapi_pkg::OP_SET_DESCR_MODE: begin
                                n_phase = dvbapi_pkg::PH_MODE;
                            end
                            dvbapi_pkg::OP_SET_DESCR_DATA: begin
                                n_phase = dvbapi_pkg::PH_DDHDR;
                            end
                            dvbapi_pkg::OP_SERVER_INFO: begin
                                n_phase = dvbapi_pkg::PH_SRVHDR;
                            end
                            dvbapi_pkg::OP_ECM_INFO: begin
                                n_phase = dvbapi_pkg::PH_ECMFIX;
                            end
                            dvbapi_pkg::OP_DMX_SET_FILTER, dvbapi_pkg::OP_DMX_STOP: begin
                                n_phase          = dvbapi_pkg::PH_HUNT;
                                w_has            = 1'b1;
                                w_res.event_kind = dvbapi_pkg::KIND_ERROR;
                                w_res.echo_id    = r_mid;
                                w_res.error_code = dvbapi_pkg::ERR_DEMUX;
                            end
                            default: begin
                                n_phase          = dvbapi_pkg::PH_HUNT;
                                w_has            = 1'b1;
                                w_res.event_kind = dvbapi_pkg::KIND_ERROR;
                                w_res.echo_id    = r_mid;
                                w_res.error_code = dvbapi_pkg::ERR_UNKNOWN;
                            end
                        endcase
                    end
                end
                dvbapi_pkg::PH_DESCR: begin
                    n_bc = w_bc_inc;
                    if (w_bc_inc == 5'd17) begin
                        n_phase            = dvbapi_pkg::PH_HUNT;
                        n_bc               = 5'd0;
                        w_has              = 1'b1;
                        w_res.event_kind   = dvbapi_pkg::KIND_CONTROL_WORD;
                        w_res.echo_id      = r_mid;
                        w_res.parity       = {r_payload[5], r_payload[6], r_payload[7],
                                              r_payload[8]};
                        w_res.control_word = {r_payload[9], r_payload[10], r_payload[11],
                                              r_payload[12], r_payload[13], r_payload[14],
                                              r_payload[15], w_byte};
                    end
                end
                dvbapi_pkg::PH_MODE: begin
                    n_bc = w_bc_inc;
                    if (w_bc_inc == 5'd13) begin
                        n_phase             = dvbapi_pkg::PH_HUNT;
                        n_bc                = 5'd0;
                        w_has               = 1'b1;
                        w_res.event_kind    = dvbapi_pkg::KIND_DESCR_MODE;
                        w_res.echo_id       = r_mid;
                        w_res.algorithm     = {r_payload[5], r_payload[6], r_payload[7],
                                               r_payload[8]};
                        w_res.scramble_mode = {r_payload[9], r_payload[10], r_payload[11],
                                               w_byte};
                    end
                end
                dvbapi_pkg::PH_DDHDR: begin
                    n_bc = w_bc_inc;
                    if (w_bc_inc == 5'd17) begin
                        n_bc   = 5'd0;
                        n_skip = {r_payload[13], r_payload[14], r_payload[15], w_byte};
                        if ({r_payload[13], r_payload[14], r_payload[15], w_byte} == 32'd0) begin
                            n_phase = dvbapi_pkg::PH_HUNT;
                        end else begin
                            n_phase = dvbapi_pkg::PH_DDSKIP;
                        end
                    end
                end
                dvbapi_pkg::PH_DDSKIP: begin
                    n_skip = w_skip_dec;
                    if (w_skip_dec == 32'd0) begin
                        n_phase = dvbapi_pkg::PH_HUNT;
                        n_bc    = 5'd0;
                    end
                end
                dvbapi_pkg::PH_SRVHDR: begin
                    n_bc = w_bc_inc;
                    if (w_bc_inc == 5'd3) begin
                        n_bc   = 5'd0;
                        n_skip = {24'd0, w_byte};
                        if (w_byte != 8'd0) begin
                            n_phase = dvbapi_pkg::PH_SRVNAME;
                        end else begin
                            n_phase                = dvbapi_pkg::PH_HUNT;
                            w_has                  = 1'b1;
                            w_res.event_kind       = dvbapi_pkg::KIND_SERVER_INFO;
                            w_res.echo_id          = r_mid;
                            w_res.protocol_version = {r_payload[0], r_payload[1]};
                        end
                    end
                end
                dvbapi_pkg::PH_SRVNAME: begin
                    n_skip = w_skip_dec;
                    if (w_skip_dec == 32'd0) begin
                        n_phase                = dvbapi_pkg::PH_HUNT;
                        n_bc                   = 5'd0;
                        w_has                  = 1'b1;
                        w_res.event_kind       = dvbapi_pkg::KIND_SERVER_INFO;
                        w_res.echo_id          = r_mid;
                        w_res.protocol_version = {r_payload[0], r_payload[1]};
                    end
                end
                dvbapi_pkg::PH_ECMFIX: begin
                    n_bc = w_bc_inc;
                    if (w_bc_inc == 5'd15) begin
                        n_bc    = 5'd0;
                        n_si    = 3'd0;
                        n_phase = dvbapi_pkg::PH_ECMLEN;
                    end
                end
                dvbapi_pkg::PH_ECMLEN: begin
                    if (w_byte == 8'd0) begin
                        n_si    = w_si_inc;
                        n_phase = w_si_inc[2] ? dvbapi_pkg::PH_HOPS : dvbapi_pkg::PH_ECMLEN;
                    end else begin
                        n_skip  = {24'd0, w_byte};
                        n_phase = dvbapi_pkg::PH_ECMSTR;
                    end
                end
                dvbapi_pkg::PH_ECMSTR: begin
                    n_skip = w_skip_dec;
                    if (w_skip_dec == 32'd0) begin
                        n_si    = w_si_inc;
                        n_phase = w_si_inc[2] ? dvbapi_pkg::PH_HOPS : dvbapi_pkg::PH_ECMLEN;
                    end
                end
                default: begin
                    n_phase = dvbapi_pkg::PH_HUNT;
                    n_bc    = 5'd0;
                    n_si    = 3'd0;
                end
            endcase
        end
    end

    assign o_take       = i_valid && (i_out_free || !w_has);
    assign o_has_result = w_has;
    assign o_result     = w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= dvbapi_pkg::PH_HUNT;
            r_bc    <= 5'd0;
            r_mid   <= 32'd0;
            r_opc   <= 32'd0;
            r_skip  <= 32'd0;
            r_si    <= 3'd0;
        end else if (o_take) begin
            r_phase <= n_phase;
            r_bc    <= n_bc;
            r_mid   <= n_mid;
            r_opc   <= n_opc;
            r_skip  <= n_skip;
            r_si    <= n_si;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && !i_item.restart && w_store && (r_bc < 5'd16)) begin
            r_payload[r_bc[3:0]] <= w_byte;
        end
    end

    `DVBAPI_ASSERT(a_count_range, i_clk, i_rst_n, r_bc <= 5'd17,
        "Payload byte count ran past the longest fixed header.")
    `DVBAPI_ASSERT(a_skip_nonzero, i_clk, i_rst_n,
        (r_phase == dvbapi_pkg::PH_DDSKIP) || (r_phase == dvbapi_pkg::PH_SRVNAME)
        || (r_phase == dvbapi_pkg::PH_ECMSTR) |-> r_skip != 32'd0,
        "A skip phase was entered with nothing left to skip.")
    `DVBAPI_ASSERT(a_restart_hunts, i_clk, i_rst_n,
        o_take && i_item.restart |=> r_phase == dvbapi_pkg::PH_HUNT && r_si == 3'd0,
        "A link restart did not return the parser to marker hunting.")
    `DVBAPI_ASSERT(a_event_phase, i_clk, i_rst_n,
        w_has |-> (r_phase == dvbapi_pkg::PH_HUNT) || (r_phase == dvbapi_pkg::PH_HEADER)
        || (r_phase == dvbapi_pkg::PH_DESCR) || (r_phase == dvbapi_pkg::PH_MODE)
        || (r_phase == dvbapi_pkg::PH_SRVHDR) || (r_phase == dvbapi_pkg::PH_SRVNAME),
        "An event was raised from a phase that consumes bytes silently.")
    `DVBAPI_ASSERT(a_error_code_clear, i_clk, i_rst_n,
        w_has && (w_res.event_kind != dvbapi_pkg::KIND_ERROR) |-> w_res.error_code == 2'd0,
        "A non-error event carried an error code.")

endmodule

// File: design/dvbapi_out_stage.sv
// ----------------------------------------------------------------------------
// DVB API parser output stage
// Result register that holds an event until the receiver takes it.
// ----------------------------------------------------------------------------
module dvbapi_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  dvbapi_pkg::t_result i_result,
    input  logic                i_ready,
    output logic                o_valid,
    output logic                o_free,
    output dvbapi_pkg::t_result o_result
);

    logic                r_valid;
    logic                n_valid;
    dvbapi_pkg::t_result r_result;

    assign o_free = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// File: test/dvbapi_v3_message_parser_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// DVB API v3 message parser testbench
// Feeds the parser byte streams of well-formed, truncated and corrupted
// messages under random source and sink idling, predicts every event from
// its own model of the parser and compares each output transaction field by
// field, in order.
// ----------------------------------------------------------------------------
module dvbapi_v3_message_parser_test;

    localparam int ITEMS_TARGET = 1950;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 8;
    localparam int TIMEOUT_NS   = 10_000_000;

    typedef logic [7:0] t_bytes [$];

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = 8'h00;   // stream_byte
    logic [0:0]   s_axis_tuser = 1'b0;    // link_restart
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // echo_id, parity, control_word, algorithm, scramble_mode,
    // protocol_version, error_code, zero fill
    logic [215:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;           // event_kind

    dvbapi_pkg::t_phase phase_q = dvbapi_pkg::PH_HUNT;
    logic [4:0]   pos_cnt = '0;
    logic [31:0]  cur_id = '0;
    logic [31:0]  cur_opcode = '0;
    logic [7:0]   body_buf [0:16] = '{default: 8'h00};
    logic [31:0]  remain_cnt = '0;
    logic [2:0]   field_idx = '0;

    dvbapi_pkg::t_result pending_events [$];
    int           mismatch_count = 0;
    int           bytes_sent = 0;
    int           stall_left = 0;
    int           hold_left = 0;
    bit           sender_idle_on = 1'b1;
    bit           receiver_idle_on = 1'b1;

    dvbapi_v3_message_parser u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    function automatic void go_hunt();
        phase_q = dvbapi_pkg::PH_HUNT;
        pos_cnt = '0;
    endfunction

    function automatic void next_field();
        field_idx = field_idx + 3'd1;
        phase_q = (field_idx >= 3'd4) ? dvbapi_pkg::PH_HOPS : dvbapi_pkg::PH_ECMLEN;
    endfunction

    function automatic logic [63:0] body_be(input int first, input int n);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < n; i++) begin
            v = {v[55:0], body_buf[first + i]};
        end
        return v;
    endfunction

    function automatic logic parse_stream_byte(input logic [7:0] b, input logic restart,
                                               output dvbapi_pkg::t_result ev);
        ev = '0;
        if (restart) begin
            go_hunt();
            remain_cnt = '0;
            field_idx = '0;
            return 1'b0;
        end
        if (phase_q == dvbapi_pkg::PH_DESCR || phase_q == dvbapi_pkg::PH_MODE ||
            phase_q == dvbapi_pkg::PH_DDHDR || phase_q == dvbapi_pkg::PH_SRVHDR ||
            phase_q == dvbapi_pkg::PH_ECMFIX) begin
            if (pos_cnt < 5'd17) begin
                body_buf[pos_cnt] = b;
            end
            pos_cnt = pos_cnt + 5'd1;
        end
        case (phase_q)
            dvbapi_pkg::PH_HUNT: begin
                if (b == dvbapi_pkg::FRAME_MARKER) begin
                    phase_q = dvbapi_pkg::PH_HEADER;
                    pos_cnt = '0;
                    return 1'b0;
                end
                ev.event_kind = dvbapi_pkg::KIND_ERROR;
                ev.error_code = dvbapi_pkg::ERR_BAD_MARKER;
                return 1'b1;
            end
            dvbapi_pkg::PH_HEADER: begin
                if (pos_cnt < 5'd4) begin
                    cur_id = {cur_id[23:0], b};
                end else begin
                    cur_opcode = {cur_opcode[23:0], b};
                end
                pos_cnt = pos_cnt + 5'd1;
                if (pos_cnt < 5'd8) begin
                    return 1'b0;
                end
                pos_cnt = '0;
                case (cur_opcode)
                    dvbapi_pkg::OP_SET_DESCR:      phase_q = dvbapi_pkg::PH_DESCR;
                    dvbapi_pkg::OP_SET_DESCR_MODE: phase_q = dvbapi_pkg::PH_MODE;
                    dvbapi_pkg::OP_SET_DESCR_DATA: phase_q = dvbapi_pkg::PH_DDHDR;
                    dvbapi_pkg::OP_SERVER_INFO:    phase_q = dvbapi_pkg::PH_SRVHDR;
                    dvbapi_pkg::OP_ECM_INFO:       phase_q = dvbapi_pkg::PH_ECMFIX;
                    dvbapi_pkg::OP_DMX_SET_FILTER, dvbapi_pkg::OP_DMX_STOP: begin
                        go_hunt();
                        ev.event_kind = dvbapi_pkg::KIND_ERROR;
                        ev.echo_id = cur_id;
                        ev.error_code = dvbapi_pkg::ERR_DEMUX;
                        return 1'b1;
                    end
                    default: begin
                        go_hunt();
                        ev.event_kind = dvbapi_pkg::KIND_ERROR;
                        ev.echo_id = cur_id;
                        ev.error_code = dvbapi_pkg::ERR_UNKNOWN;
                        return 1'b1;
                    end
                endcase
                return 1'b0;
            end
            dvbapi_pkg::PH_DESCR: begin
                if (pos_cnt < 5'd17) begin
                    return 1'b0;
                end
                go_hunt();
                ev.event_kind = dvbapi_pkg::KIND_CONTROL_WORD;
                ev.echo_id = cur_id;
                ev.parity = 32'(body_be(5, 4));
                ev.control_word = body_be(9, 8);
                return 1'b1;
            end
            dvbapi_pkg::PH_MODE: begin
                if (pos_cnt < 5'd13) begin
                    return 1'b0;
                end
                go_hunt();
                ev.event_kind = dvbapi_pkg::KIND_DESCR_MODE;
                ev.echo_id = cur_id;
                ev.algorithm = 32'(body_be(5, 4));
                ev.scramble_mode = 32'(body_be(9, 4));
                return 1'b1;
            end
            dvbapi_pkg::PH_DDHDR: begin
                if (pos_cnt < 5'd17) begin
                    return 1'b0;
                end
                remain_cnt = 32'(body_be(13, 4));
                pos_cnt = '0;
                if (remain_cnt == 0) begin
                    go_hunt();
                end else begin
                    phase_q = dvbapi_pkg::PH_DDSKIP;
                end
                return 1'b0;
            end
            dvbapi_pkg::PH_DDSKIP: begin
                remain_cnt = remain_cnt - 32'd1;
                if (remain_cnt == 0) begin
                    go_hunt();
                end
                return 1'b0;
            end
            dvbapi_pkg::PH_SRVHDR: begin
                if (pos_cnt < 5'd3) begin
                    return 1'b0;
                end
                pos_cnt = '0;
                remain_cnt = {24'd0, body_buf[2]};
                if (remain_cnt != 0) begin
                    phase_q = dvbapi_pkg::PH_SRVNAME;
                    return 1'b0;
                end
                go_hunt();
                ev.event_kind = dvbapi_pkg::KIND_SERVER_INFO;
                ev.echo_id = cur_id;
                ev.protocol_version = 16'(body_be(0, 2));
                return 1'b1;
            end
            dvbapi_pkg::PH_SRVNAME: begin
                remain_cnt = remain_cnt - 32'd1;
                if (remain_cnt != 0) begin
                    return 1'b0;
                end
                go_hunt();
                ev.event_kind = dvbapi_pkg::KIND_SERVER_INFO;
                ev.echo_id = cur_id;
                ev.protocol_version = 16'(body_be(0, 2));
                return 1'b1;
            end
            dvbapi_pkg::PH_ECMFIX: begin
                if (pos_cnt < 5'd15) begin
                    return 1'b0;
                end
                pos_cnt = '0;
                field_idx = '0;
                phase_q = dvbapi_pkg::PH_ECMLEN;
                return 1'b0;
            end
            dvbapi_pkg::PH_ECMLEN: begin
                if (b == 8'h00) begin
                    next_field();
                    return 1'b0;
                end
                remain_cnt = {24'd0, b};
                phase_q = dvbapi_pkg::PH_ECMSTR;
                return 1'b0;
            end
            dvbapi_pkg::PH_ECMSTR: begin
                remain_cnt = remain_cnt - 32'd1;
                if (remain_cnt == 0) begin
                    next_field();
                end
                return 1'b0;
            end
            default: begin
                go_hunt();
                field_idx = '0;
                return 1'b0;
            end
        endcase
        return 1'b0;
    endfunction

    function automatic t_bytes rand_bytes(input int n);
        t_bytes q;
        repeat (n) q.push_back(8'($urandom_range(0, 255)));
        return q;
    endfunction

    function automatic t_bytes const_bytes(input int n, input logic [7:0] v);
        t_bytes q;
        repeat (n) q.push_back(v);
        return q;
    endfunction

    function automatic void add_counted(ref t_bytes q, input int n);
        q.push_back(8'(n));
        repeat (n) q.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic t_bytes frame(input logic [31:0] id, input logic [31:0] op,
                                     input t_bytes body);
        t_bytes q;
        q.push_back(dvbapi_pkg::FRAME_MARKER);
        for (int i = 3; i >= 0; i--) q.push_back(id[8*i +: 8]);
        for (int i = 3; i >= 0; i--) q.push_back(op[8*i +: 8]);
        foreach (body[i]) q.push_back(body[i]);
        return q;
    endfunction

    function automatic t_bytes data_body(input logic [31:0] len, input int tail);
        t_bytes q;
        q = rand_bytes(17);
        for (int i = 0; i < 4; i++) q[13 + i] = len[31 - 8*i -: 8];
        repeat (tail) q.push_back(8'($urandom_range(0, 255)));
        return q;
    endfunction

    function automatic t_bytes server_body(input logic [15:0] version, input int label_len);
        t_bytes q;
        q.push_back(version[15:8]);
        q.push_back(version[7:0]);
        add_counted(q, label_len);
        return q;
    endfunction

    function automatic int pick_short_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 0;
        if (r < 97) return $urandom_range(1, 6);
        return $urandom_range(7, 255);
    endfunction

    function automatic logic [31:0] random_id();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 32'h0000_0000;
        if (r == 1) return 32'hFFFF_FFFF;
        return $urandom();
    endfunction

    function automatic t_bytes random_message();
        t_bytes body;
        logic [31:0] op;
        logic [31:0] len;
        logic [31:0] known [7];
        int sel;
        int r;
        known = '{dvbapi_pkg::OP_SET_DESCR, dvbapi_pkg::OP_SET_DESCR_MODE,
                  dvbapi_pkg::OP_SET_DESCR_DATA, dvbapi_pkg::OP_DMX_SET_FILTER,
                  dvbapi_pkg::OP_DMX_STOP, dvbapi_pkg::OP_SERVER_INFO,
                  dvbapi_pkg::OP_ECM_INFO};
        sel = $urandom_range(0, 99);
        if (sel < 18) begin
            op = dvbapi_pkg::OP_SET_DESCR;
            body = rand_bytes(17);
        end else if (sel < 32) begin
            op = dvbapi_pkg::OP_SET_DESCR_MODE;
            body = rand_bytes(13);
        end else if (sel < 44) begin
            op = dvbapi_pkg::OP_SET_DESCR_DATA;
            r = $urandom_range(0, 99);
            len = (r < 15) ? 0 : (r < 97) ? $urandom_range(1, 12) : $urandom_range(100, 300);
            body = data_body(len, len);
        end else if (sel < 56) begin
            op = dvbapi_pkg::OP_SERVER_INFO;
            body = server_body(16'($urandom_range(0, 65535)), pick_short_len());
        end else if (sel < 70) begin
            op = dvbapi_pkg::OP_ECM_INFO;
            body = rand_bytes(15);
            repeat (4) add_counted(body, pick_short_len());
            body.push_back(8'($urandom_range(0, 255)));
        end else if (sel < 80) begin
            op = $urandom_range(0, 1) ? dvbapi_pkg::OP_DMX_SET_FILTER : dvbapi_pkg::OP_DMX_STOP;
        end else if (sel < 90) begin
            op = known[$urandom_range(0, 6)] ^ (32'd1 << $urandom_range(0, 31));
        end else begin
            op = $urandom();
        end
        return frame(random_id(), op, body);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic restart);
        int gap;
        dvbapi_pkg::t_result ev;
        gap = sender_idle_on ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= restart;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (parse_stream_byte(b, restart, ev)) begin
            pending_events.push_back(ev);
        end
        bytes_sent++;
    endtask

    task automatic send_bytes(input t_bytes q);
        foreach (q[i]) send_byte(q[i], 1'b0);
    endtask

    task automatic wait_drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [63:0] want_v,
                               input logic [63:0] got_v);
        if (got_v !== want_v) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, want_v, got_v);
            end
        end
    endtask

    always @(posedge i_clk) begin : result_check
        dvbapi_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            stall_left = receiver_idle_on ? $urandom_range(0, 11) : 0;
            if (pending_events.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("%0t: unexpected event, kind %0d, data %h", $time,
                             m_axis_tuser, m_axis_tdata);
                end
            end else begin
                want = pending_events.pop_front();
                check_field("event_kind", 64'(want.event_kind), 64'(m_axis_tuser));
                check_field("echo_id", 64'(want.echo_id), 64'(m_axis_tdata[31:0]));
                check_field("parity", 64'(want.parity), 64'(m_axis_tdata[63:32]));
                check_field("control_word", want.control_word, m_axis_tdata[127:64]);
                check_field("algorithm", 64'(want.algorithm), 64'(m_axis_tdata[159:128]));
                check_field("scramble_mode", 64'(want.scramble_mode),
                            64'(m_axis_tdata[191:160]));
                check_field("protocol_version", 64'(want.protocol_version),
                            64'(m_axis_tdata[207:192]));
                check_field("error_code", 64'(want.error_code), 64'(m_axis_tdata[209:208]));
                check_field("zero_fill", 64'd0, 64'(m_axis_tdata[215:210]));
            end
        end
    end

    initial begin : event_sink
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic test_bad_markers();
        send_bytes('{8'h00, 8'hFF, 8'hA4, 8'h5A, 8'h25, 8'h85});
    endtask

    task automatic test_control_words();
        send_bytes(frame(32'h0000_0000, dvbapi_pkg::OP_SET_DESCR, const_bytes(17, 8'h00)));
        send_bytes(frame(32'hFFFF_FFFF, dvbapi_pkg::OP_SET_DESCR, const_bytes(17, 8'hFF)));
        send_bytes(frame($urandom(), dvbapi_pkg::OP_SET_DESCR, rand_bytes(17)));
    endtask

    task automatic test_descriptor_modes();
        send_bytes(frame(32'hFFFF_FFFF, dvbapi_pkg::OP_SET_DESCR_MODE, const_bytes(13, 8'hFF)));
        send_bytes(frame(32'h0000_0000, dvbapi_pkg::OP_SET_DESCR_MODE, const_bytes(13, 8'h00)));
    endtask

    task automatic test_demux_and_unknown();
        t_bytes none;
        send_bytes(frame($urandom(), dvbapi_pkg::OP_DMX_SET_FILTER, none));
        send_bytes(frame($urandom(), dvbapi_pkg::OP_DMX_STOP, none));
        send_bytes(frame($urandom(), 32'h0000_0000, none));
        send_bytes(frame($urandom(), 32'hFFFF_FFFF, none));
    endtask

    task automatic test_descriptor_data();
        send_bytes(frame($urandom(), dvbapi_pkg::OP_SET_DESCR_DATA, data_body(0, 0)));
        send_bytes(frame($urandom(), dvbapi_pkg::OP_SET_DESCR_DATA, data_body(3, 3)));
        send_bytes(frame($urandom(), dvbapi_pkg::OP_SET_DESCR_DATA,
                         data_body(32'hFFFF_FFFF, 5)));
        send_byte(8'hA5, 1'b1);
        send_bytes(frame($urandom(), dvbapi_pkg::OP_SET_DESCR, rand_bytes(17)));
    endtask

    task automatic test_server_info();
        send_bytes(frame($urandom(), dvbapi_pkg::OP_SERVER_INFO, server_body(16'hFFFF, 0)));
        send_bytes(frame($urandom(), dvbapi_pkg::OP_SERVER_INFO, server_body(16'h0000, 3)));
        send_bytes(frame($urandom(), dvbapi_pkg::OP_SERVER_INFO, server_body(16'h0003, 1)));
    endtask

    task automatic test_ecm_info();
        t_bytes body;
        body = rand_bytes(15);
        repeat (4) add_counted(body, 0);
        body.push_back(8'h00);
        send_bytes(frame($urandom(), dvbapi_pkg::OP_ECM_INFO, body));
        body = rand_bytes(15);
        add_counted(body, 1);
        add_counted(body, 0);
        add_counted(body, 2);
        add_counted(body, 5);
        body.push_back(8'hFF);
        send_bytes(frame($urandom(), dvbapi_pkg::OP_ECM_INFO, body));
        send_bytes(frame($urandom(), dvbapi_pkg::OP_SET_DESCR_MODE, rand_bytes(13)));
    endtask

    task automatic test_link_restart();
        t_bytes msg;
        t_bytes part;
        send_byte(8'h00, 1'b1);
        msg = frame($urandom(), dvbapi_pkg::OP_SET_DESCR, rand_bytes(17));
        part = msg[0:4];
        send_bytes(part);
        send_byte(8'hA5, 1'b1);
        part = msg[0:14];
        send_bytes(part);
        send_byte(8'h5A, 1'b1);
        msg = rand_bytes(15);
        msg.push_back(8'h04);
        msg.push_back(8'h11);
        msg.push_back(8'h22);
        send_bytes(frame($urandom(), dvbapi_pkg::OP_ECM_INFO, msg));
        send_byte(8'hFF, 1'b1);
        send_bytes(frame($urandom(), dvbapi_pkg::OP_SET_DESCR_MODE, rand_bytes(13)));
    endtask

    task automatic test_sink_hold();
        hold_left = HOLD_CYCLES;
        repeat (40) send_byte(8'($urandom_range(0, 164)), 1'b0);
    endtask

    task automatic test_drain_pause();
        repeat (3) send_bytes(random_message());
        wait_drain();
        repeat (3) send_bytes(random_message());
    endtask

    task automatic test_random_stream();
        t_bytes msg;
        int r;
        int cut;
        while (bytes_sent < ITEMS_TARGET) begin
            if ($urandom_range(0, 29) == 0) begin
                sender_idle_on = ($urandom_range(0, 3) != 0);
                receiver_idle_on = ($urandom_range(0, 3) != 0);
            end
            r = $urandom_range(0, 99);
            msg = random_message();
            if (r < 80) begin
                send_bytes(msg);
            end else if (r < 88) begin
                send_bytes(rand_bytes($urandom_range(1, 4)));
            end else if (r < 96) begin
                cut = $urandom_range(1, msg.size() - 1);
                msg = msg[0:cut-1];
                send_bytes(msg);
                if ($urandom_range(0, 1)) send_byte(8'($urandom_range(0, 255)), 1'b1);
            end else begin
                send_byte(8'($urandom_range(0, 255)), 1'b1);
            end
        end
    endtask

    initial begin : stimulus
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_bad_markers();
        test_control_words();
        test_descriptor_modes();
        test_demux_and_unknown();
        test_descriptor_data();
        test_server_info();
        test_ecm_info();
        test_link_restart();
        test_sink_hold();
        test_drain_pause();
        test_random_stream();
        wait_drain();
        if (mismatch_count == 0 && pending_events.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("FAILURE");
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/dvbapi_pkg.sv
design/dvbapi_in_stage.sv
design/dvbapi_core.sv
design/dvbapi_out_stage.sv
design/dvbapi_v3_message_parser.sv
test/dvbapi_v3_message_parser_test.sv
